[rtl/rect_free_space_packer_unit_assert.svh]
// Assertion macros for the free-space packer checker.
// Both macros sample on clk and are disabled while rst_n is low.
`ifndef RECT_FREE_SPACE_PACKER_UNIT_ASSERT_SVH
`define RECT_FREE_SPACE_PACKER_UNIT_ASSERT_SVH

// Condition implies a consequence in the same cycle.
`define RFSP_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Condition implies a consequence in the next cycle.
`define RFSP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/rfsp_pkg.sv]
// Shared types and constants of the free-space rectangle packer.
// No dependencies.
`timescale 1ns / 1ps

package rfsp_pkg;

    localparam int COORD_W   = 13;
    localparam int CFG_IDX_W = 8;
    localparam int FIELD_MAX = (1 << COORD_W) - 1;

    localparam logic [COORD_W-1:0] BIN_RESET = COORD_W'(1024);

    localparam logic [CFG_IDX_W-1:0] CFG_BIN_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_BIN_HEIGHT = CFG_IDX_W'(1);

    typedef struct packed {
        logic [COORD_W-1:0] left;
        logic [COORD_W-1:0] top;
        logic [COORD_W-1:0] right;
        logic [COORD_W-1:0] bottom;
    } space_t;

    typedef struct packed {
        logic [COORD_W-1:0] area_width;
        logic [COORD_W-1:0] area_height;
    } req_t;

    typedef struct packed {
        logic               placed;
        logic [COORD_W-1:0] rect_left;
        logic [COORD_W-1:0] rect_top;
        logic [COORD_W-1:0] rect_right;
        logic [COORD_W-1:0] rect_bottom;
        logic               space_overflow;
    } rsp_t;

    typedef struct packed {
        logic [CFG_IDX_W-1:0] index;
        logic [COORD_W-1:0]   value;
    } cfg_t;

    typedef struct packed {
        space_t             keep;
        space_t             extra;
        logic               exact;
        logic               add_extra;
        logic [COORD_W-1:0] right;
        logic [COORD_W-1:0] bottom;
    } split_t;

endpackage

[rtl/rfsp_stream_if.sv]
// Valid/ready channel carrying one payload item of type T.
// No dependencies.
`timescale 1ns / 1ps

interface rfsp_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[rtl/rfsp_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module rfsp_ram #(
    parameter int WIDTH = 52,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[rtl/rfsp_split.sv]
// Split of a chosen free space around the placed rectangle.
// Depends on rfsp_pkg.
`timescale 1ns / 1ps

module rfsp_split
    import rfsp_pkg::*;
(
    input  space_t             space,
    input  logic [COORD_W-1:0] aw,
    input  logic [COORD_W-1:0] ah,
    output split_t             res
);

    logic [COORD_W-1:0] sw;
    logic [COORD_W-1:0] sh;
    logic [COORD_W-1:0] fw;
    logic [COORD_W-1:0] fh;
    logic [COORD_W-1:0] new_left;
    logic [COORD_W-1:0] new_top;

    always_comb
    begin
        sw       = (space.right >= space.left) ? space.right - space.left : '0;
        sh       = (space.bottom >= space.top) ? space.bottom - space.top : '0;
        fw       = sw - aw;
        fh       = sh - ah;
        new_left = space.left + aw;
        new_top  = space.top + ah;

        res.keep      = space;
        res.extra     = space;
        res.exact     = (fw == '0) && (fh == '0);
        res.add_extra = 1'b0;
        res.right     = new_left;
        res.bottom    = new_top;

        if (fh == '0)
        begin
            res.keep.left = new_left;
        end
        else if (fw == '0)
        begin
            res.keep.top = new_top;
        end
        else if (fw > fh)
        begin
            // keep the right-hand piece, append the piece below
            res.keep.left    = new_left;
            res.extra.top    = new_top;
            res.extra.right  = new_left;
            res.add_extra    = 1'b1;
        end
        else
        begin
            // keep the lower piece, append the piece to the right
            res.keep.top     = new_top;
            res.extra.left   = new_left;
            res.extra.bottom = new_top;
            res.add_extra    = 1'b1;
        end
    end

endmodule

[rtl/rfsp_ctrl.sv]
// Scan and update sequencer around the free-space table memory.
// Depends on rfsp_pkg, rfsp_ram and rfsp_split.
`timescale 1ns / 1ps

module rfsp_ctrl
    import rfsp_pkg::*;
#(
    parameter int MAX_SPACES = 256
) (
    input  logic   clk,
    input  logic   rst_n,
    input  logic   restart,
    input  space_t init_entry,
    input  logic   req_valid,
    input  req_t   req_data,
    output logic   req_ready,
    output logic   rsp_valid,
    output rsp_t   rsp_data,
    input  logic   rsp_ready
);

    localparam int IW = $clog2(MAX_SPACES);
    localparam int CW = $clog2(MAX_SPACES + 1);
    localparam logic [CW-1:0] COUNT_FULL = CW'(MAX_SPACES);

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_SCAN,
        ST_HIT,
        ST_MOVE,
        ST_KEEP,
        ST_EXTRA,
        ST_DONE
    } state_t;

    state_t             state_reg;
    logic [CW-1:0]      count_reg;
    logic [IW-1:0]      ptr_reg;
    logic               issue_reg;
    logic               chk_reg;
    logic [IW-1:0]      chk_idx_reg;
    logic [IW-1:0]      hit_idx_reg;
    logic [COORD_W-1:0] aw_reg;
    logic [COORD_W-1:0] ah_reg;
    space_t             space_reg;
    split_t             split_reg;
    logic               hit_reg;
    logic               ovf_reg;
    logic               out_valid_reg;
    rsp_t               out_reg;

    logic               ram_we;
    logic [IW-1:0]      ram_waddr;
    space_t             ram_wdata;
    logic               ram_re;
    logic [IW-1:0]      ram_raddr;
    space_t             ram_rdata;
    split_t             split_res;

    logic [IW-1:0]      last_idx;
    logic [COORD_W-1:0] rd_sw;
    logic [COORD_W-1:0] rd_sh;
    logic               fits;
    logic               room;
    logic               out_free;

    rfsp_ram #(
        .WIDTH ($bits(space_t)),
        .DEPTH (MAX_SPACES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    rfsp_split u_split (
        .space (space_reg),
        .aw    (aw_reg),
        .ah    (ah_reg),
        .res   (split_res)
    );

    assign last_idx  = IW'(count_reg - CW'(1));
    assign room      = (count_reg != COUNT_FULL);
    assign out_free  = !out_valid_reg || rsp_ready;
    assign req_ready = (state_reg == ST_IDLE);
    assign rsp_valid = out_valid_reg;
    assign rsp_data  = out_reg;

    always_comb
    begin
        rd_sw = (ram_rdata.right >= ram_rdata.left) ? ram_rdata.right - ram_rdata.left : '0;
        rd_sh = (ram_rdata.bottom >= ram_rdata.top) ? ram_rdata.bottom - ram_rdata.top : '0;
        fits  = (aw_reg <= rd_sw) && (ah_reg <= rd_sh);
    end

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = last_idx;
        ram_wdata = split_reg.keep;
        ram_re    = 1'b0;
        ram_raddr = ptr_reg;
        case (state_reg)
            ST_INIT:
            begin
                ram_we    = 1'b1;
                ram_waddr = '0;
                ram_wdata = init_entry;
            end
            ST_SCAN:
            begin
                ram_re = issue_reg;
            end
            ST_HIT:
            begin
                ram_re    = 1'b1;
                ram_raddr = last_idx;
            end
            ST_MOVE:
            begin
                // last entry fills the slot of the taken space
                ram_we    = 1'b1;
                ram_waddr = hit_idx_reg;
                ram_wdata = ram_rdata;
            end
            ST_KEEP:
            begin
                ram_we = 1'b1;
            end
            ST_EXTRA:
            begin
                ram_we    = room;
                ram_waddr = IW'(count_reg);
                ram_wdata = split_reg.extra;
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            count_reg     <= '0;
            issue_reg     <= 1'b0;
            chk_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (restart)
        begin
            // rebuild the table from the bin registers
            state_reg <= ST_INIT;
            if (out_valid_reg && rsp_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
        else
        begin
            if (out_valid_reg && rsp_ready && (state_reg != ST_DONE))
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_INIT:
                begin
                    count_reg <= CW'(1);
                    state_reg <= ST_IDLE;
                end
                ST_IDLE:
                begin
                    if (req_valid)
                    begin
                        aw_reg    <= req_data.area_width;
                        ah_reg    <= req_data.area_height;
                        ovf_reg   <= 1'b0;
                        ptr_reg   <= last_idx;
                        chk_reg   <= 1'b0;
                        if (count_reg == '0)
                        begin
                            hit_reg   <= 1'b0;
                            issue_reg <= 1'b0;
                            state_reg <= ST_DONE;
                        end
                        else
                        begin
                            issue_reg <= 1'b1;
                            state_reg <= ST_SCAN;
                        end
                    end
                end
                ST_SCAN:
                begin
                    if (chk_reg && fits)
                    begin
                        hit_reg     <= 1'b1;
                        hit_idx_reg <= chk_idx_reg;
                        space_reg   <= ram_rdata;
                        issue_reg   <= 1'b0;
                        chk_reg     <= 1'b0;
                        state_reg   <= ST_HIT;
                    end
                    else if (chk_reg && (chk_idx_reg == '0))
                    begin
                        hit_reg   <= 1'b0;
                        issue_reg <= 1'b0;
                        chk_reg   <= 1'b0;
                        state_reg <= ST_DONE;
                    end
                    else
                    begin
                        // advance the read pointer from newest to oldest
                        chk_reg     <= issue_reg;
                        chk_idx_reg <= ptr_reg;
                        if (issue_reg)
                        begin
                            if (ptr_reg == '0)
                            begin
                                issue_reg <= 1'b0;
                            end
                            else
                            begin
                                ptr_reg <= ptr_reg - IW'(1);
                            end
                        end
                    end
                end
                ST_HIT:
                begin
                    split_reg <= split_res;
                    state_reg <= ST_MOVE;
                end
                ST_MOVE:
                begin
                    if (split_reg.exact)
                    begin
                        count_reg <= count_reg - CW'(1);
                        state_reg <= ST_DONE;
                    end
                    else
                    begin
                        state_reg <= ST_KEEP;
                    end
                end
                ST_KEEP:
                begin
                    state_reg <= split_reg.add_extra ? ST_EXTRA : ST_DONE;
                end
                ST_EXTRA:
                begin
                    if (room)
                    begin
                        count_reg <= count_reg + CW'(1);
                    end
                    else
                    begin
                        // drop the second piece
                        ovf_reg <= 1'b1;
                    end
                    state_reg <= ST_DONE;
                end
                ST_DONE:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        if (hit_reg)
                        begin
                            out_reg.placed         <= 1'b1;
                            out_reg.rect_left      <= space_reg.left;
                            out_reg.rect_top       <= space_reg.top;
                            out_reg.rect_right     <= split_reg.right;
                            out_reg.rect_bottom    <= split_reg.bottom;
                            out_reg.space_overflow <= ovf_reg;
                        end
                        else
                        begin
                            out_reg <= '0;
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_INIT;
                end
            endcase
        end
    end

endmodule

[rtl/rect_free_space_packer_unit.sv]
// Guillotine free-space rectangle packer, top level.
//
// Channels: req (sink) carries area_width/area_height, rsp (source) carries
// placed, rect_left/top/right/bottom and space_overflow, cfg (sink) carries
// a register index and 13-bit value (0: bin_width, 1: bin_height, others
// ignored). All three move one item at an edge where valid and ready are high.
// A request scans the free-space memory from the newest entry down, one
// read per cycle, then rewrites up to three entries. After the scan the
// HIT, MOVE, KEEP and EXTRA states do the update and DONE loads the result;
// a miss skips the update and an exact fit goes from MOVE straight to DONE.
// One request is worked at a time: req is ready only in the idle state, so a
// new request is taken only once the last result is in the output register.
// Reset and every bin register write restart the table: the INIT state writes
// entry 0 with the bin (clamped to COORD_MAX), and req is held off then.
// The result sits in an output register; while rsp is stalled a new
// request is still taken and scanned, and its result waits for the slot.
// Depends on rfsp_pkg, rfsp_stream_if and rfsp_ctrl.
`timescale 1ns / 1ps

module rect_free_space_packer_unit
    import rfsp_pkg::*;
#(
    parameter int MAX_SPACES = 256,
    parameter int COORD_MAX  = 4096
) (
    input  logic                clk,
    input  logic                rst_n,
    rfsp_stream_if.sink         req,
    rfsp_stream_if.source       rsp,
    rfsp_stream_if.sink         cfg
);

    localparam logic [COORD_W-1:0] CLAMP_VAL =
        (COORD_MAX > FIELD_MAX) ? COORD_W'(FIELD_MAX) : COORD_W'(COORD_MAX);

    logic [COORD_W-1:0] bin_width_reg;
    logic [COORD_W-1:0] bin_height_reg;
    logic               restart;
    logic               cfg_write;
    space_t             init_entry;
    req_t               req_item;
    rsp_t               rsp_item;

    assign cfg.ready = 1'b1;
    assign cfg_write = cfg.valid;
    assign restart   = cfg_write &&
                       ((cfg.data.index == CFG_BIN_WIDTH) || (cfg.data.index == CFG_BIN_HEIGHT));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bin_width_reg  <= BIN_RESET;
            bin_height_reg <= BIN_RESET;
        end
        else if (cfg_write)
        begin
            if (cfg.data.index == CFG_BIN_WIDTH)
            begin
                bin_width_reg <= cfg.data.value;
            end
            if (cfg.data.index == CFG_BIN_HEIGHT)
            begin
                bin_height_reg <= cfg.data.value;
            end
        end
    end

    always_comb
    begin
        init_entry.left   = '0;
        init_entry.top    = '0;
        init_entry.right  = (bin_width_reg > CLAMP_VAL) ? CLAMP_VAL : bin_width_reg;
        init_entry.bottom = (bin_height_reg > CLAMP_VAL) ? CLAMP_VAL : bin_height_reg;
    end

    assign req_item = req.data;
    assign rsp.data = rsp_item;

    rfsp_ctrl #(
        .MAX_SPACES (MAX_SPACES)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .restart    (restart),
        .init_entry (init_entry),
        .req_valid  (req.valid),
        .req_data   (req_item),
        .req_ready  (req.ready),
        .rsp_valid  (rsp.valid),
        .rsp_data   (rsp_item),
        .rsp_ready  (rsp.ready)
    );

endmodule

[rtl/rfsp_checker.sv]
// Port-level checks of the free-space packer, bound to the top level.
// Depends on rfsp_pkg and rect_free_space_packer_unit_assert.svh.
`timescale 1ns / 1ps
`include "rect_free_space_packer_unit_assert.svh"

module rfsp_checker
    import rfsp_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic req_valid,
    input logic req_ready,
    input logic rsp_valid,
    input logic rsp_ready,
    input rsp_t rsp_data
);

    // one request at a time: no new item right after an accept
    `RFSP_ASSERT_NEXT(a_one_in_flight, req_valid && req_ready, !req_ready, "request taken while busy")

    `RFSP_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "stalled result changed")

    `RFSP_ASSERT_IMP(a_miss_zero, rsp_valid && !rsp_data.placed, (rsp_data.rect_left == '0) && (rsp_data.rect_top == '0) && (rsp_data.rect_right == '0) && (rsp_data.rect_bottom == '0) && !rsp_data.space_overflow, "miss with non-zero fields")

    `RFSP_ASSERT_IMP(a_rect_order, rsp_valid && rsp_data.placed, (rsp_data.rect_right >= rsp_data.rect_left) && (rsp_data.rect_bottom >= rsp_data.rect_top), "placed rectangle inverted")

endmodule

bind rect_free_space_packer_unit rfsp_checker u_rfsp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_data  (rsp.data)
);

[verif/tb_rect_free_space_packer_unit.sv]
// Self-checking bench for the free-space rectangle packer top level: it predicts
// each placement, checks every result field and sweeps several bin sizes.
// Depends on rfsp_pkg, rfsp_stream_if and rect_free_space_packer_unit.
`timescale 1ns / 1ps

module tb_rect_free_space_packer_unit;
    import rfsp_pkg::*;

    localparam int MAX_SPACES    = 256;
    localparam int COORD_MAX     = 4096;
    localparam int GAP_MAX       = 17;
    localparam int SETTLE_CYCLES = 4;
    localparam int TAIL_CYCLES   = MAX_SPACES + 16;
    localparam int CYCLE_LIMIT   = 3_000_000;
    localparam int REPORT_MAX    = 10;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LOW  = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HIGH = '1;

    typedef enum int { MIX_BROAD, MIX_SMALL } area_mix_t;

    logic clk = 1'b0;
    logic rst_n;

    rfsp_stream_if #(.T(req_t)) req_ch ();
    rfsp_stream_if #(.T(rsp_t)) rsp_ch ();
    rfsp_stream_if #(.T(cfg_t)) cfg_ch ();

    rect_free_space_packer_unit #(
        .MAX_SPACES (MAX_SPACES),
        .COORD_MAX  (COORD_MAX)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    always #1 clk = ~clk;

    // Shadow of the free-space table and the bin registers
    space_t             free_spaces [MAX_SPACES];
    int                 free_count = 0;
    logic [COORD_W-1:0] bin_w = BIN_RESET;
    logic [COORD_W-1:0] bin_h = BIN_RESET;

    req_t queued_areas [$];
    rsp_t awaited_rsps [$];

    int fail_count   = 0;
    int report_count = 0;
    int n_requests   = 0;
    int n_placed     = 0;
    int n_overflow   = 0;
    int n_results    = 0;
    int n_reg_writes = 0;
    int cycle_count  = 0;

    int req_wait;
    int rsp_wait;
    bit req_burst;
    bit rsp_burst;

    function automatic void restart_free_list();
        free_spaces[0].left   = '0;
        free_spaces[0].top    = '0;
        free_spaces[0].right  = (bin_w > COORD_MAX) ? COORD_W'(COORD_MAX) : bin_w;
        free_spaces[0].bottom = (bin_h > COORD_MAX) ? COORD_W'(COORD_MAX) : bin_h;
        free_count = 1;
    endfunction

    // Take the newest space that holds the area and update the table
    function automatic rsp_t place_rect(req_t area);
        rsp_t   res;
        space_t s;
        space_t keep;
        space_t extra;
        int     aw;
        int     ah;
        int     sw;
        int     sh;
        int     fw;
        int     fh;
        int     last;
        int     idx;
        bit     add_extra;
        res = '0;
        aw  = int'(area.area_width);
        ah  = int'(area.area_height);
        for (idx = free_count - 1; idx >= 0; idx--) begin
            s  = free_spaces[idx];
            sw = (s.right >= s.left) ? int'(s.right) - int'(s.left) : 0;
            sh = (s.bottom >= s.top) ? int'(s.bottom) - int'(s.top) : 0;
            if (aw <= sw && ah <= sh) begin
                fw   = sw - aw;
                fh   = sh - ah;
                last = free_count - 1;
                res.placed      = 1'b1;
                res.rect_left   = s.left;
                res.rect_top    = s.top;
                res.rect_right  = COORD_W'(int'(s.left) + aw);
                res.rect_bottom = COORD_W'(int'(s.top) + ah);
                if (fw == 0 && fh == 0) begin
                    free_spaces[idx] = free_spaces[last];
                    free_count = last;
                end
                else begin
                    keep      = s;
                    extra     = s;
                    add_extra = 1'b0;
                    if (fh == 0) begin
                        keep.left = COORD_W'(int'(s.left) + aw);
                    end
                    else if (fw == 0) begin
                        keep.top = COORD_W'(int'(s.top) + ah);
                    end
                    else if (fw > fh) begin
                        keep.left   = COORD_W'(int'(s.left) + aw);
                        extra.top   = COORD_W'(int'(s.top) + ah);
                        extra.right = COORD_W'(int'(s.left) + aw);
                        add_extra   = 1'b1;
                    end
                    else begin
                        keep.top     = COORD_W'(int'(s.top) + ah);
                        extra.left   = COORD_W'(int'(s.left) + aw);
                        extra.bottom = COORD_W'(int'(s.top) + ah);
                        add_extra    = 1'b1;
                    end
                    free_spaces[idx]  = free_spaces[last];
                    free_spaces[last] = keep;
                    if (add_extra) begin
                        if (free_count < MAX_SPACES) begin
                            free_spaces[free_count] = extra;
                            free_count++;
                        end
                        else begin
                            res.space_overflow = 1'b1;
                        end
                    end
                end
                return res;
            end
        end
        return res;
    endfunction

    function automatic void check_field(string field, logic [COORD_W-1:0] want,
                                        logic [COORD_W-1:0] got);
        if (got !== want) begin
            fail_count++;
            if (report_count < REPORT_MAX)
                $display("result %0d: %s expected %0d, got %0d", n_results, field, want, got);
            report_count++;
        end
    endfunction

    // Broad mix: half the areas shaped after spaces that are free now, most others plain
    // random, a few oversized ones that use every bit of the fields; small mix: mostly up to 32 by 32
    function automatic req_t draw_area(area_mix_t mix);
        req_t   a;
        space_t s;
        int     bw;
        int     bh;
        int     sw;
        int     sh;
        int     w;
        int     h;
        int     roll;
        bw   = (bin_w > COORD_MAX) ? COORD_MAX : int'(bin_w);
        bh   = (bin_h > COORD_MAX) ? COORD_MAX : int'(bin_h);
        roll = $urandom_range(0, 99);
        s    = (free_count > 0) ? free_spaces[$urandom_range(0, free_count - 1)] : '0;
        sw   = int'(s.right) - int'(s.left);
        sh   = int'(s.bottom) - int'(s.top);
        if (mix == MIX_SMALL && roll < 85) begin
            w = $urandom_range(1, 32);
            h = $urandom_range(1, 32);
        end
        else if (roll < 35 && free_count > 0) begin
            w = sw;
            h = sh;
        end
        else if (roll < 50 && free_count > 0) begin
            if ($urandom_range(0, 1) != 0) begin
                w = sw;
                h = $urandom_range(0, sh);
            end
            else begin
                w = $urandom_range(0, sw);
                h = sh;
            end
        end
        else if (roll < 88) begin
            w = $urandom_range(0, bw / 4 + 1);
            h = $urandom_range(0, bh / 4 + 1);
        end
        else if (roll < 95) begin
            w = $urandom_range(0, bw);
            h = $urandom_range(0, bh);
        end
        else begin
            w = $urandom_range(0, FIELD_MAX);
            h = $urandom_range(0, FIELD_MAX);
        end
        a.area_width  = COORD_W'(w);
        a.area_height = COORD_W'(h);
        return a;
    endfunction

    // Request driver: hold an item until taken, then idle for the drawn gap
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            req_ch.valid <= 1'b0;
            req_ch.data  <= '0;
            req_wait     <= 0;
            req_burst    <= 1'b0;
        end
        else if (!req_ch.valid || req_ch.ready) begin
            if (req_wait > 0) begin
                req_ch.valid <= 1'b0;
                req_wait     <= req_wait - 1;
            end
            else if (queued_areas.size() != 0) begin
                req_ch.valid <= 1'b1;
                req_ch.data  <= queued_areas.pop_front();
                req_wait     <= req_burst ? 0 : $urandom_range(0, GAP_MAX);
                if ($urandom_range(0, 39) == 0)
                    req_burst <= ~req_burst;
            end
            else begin
                req_ch.valid <= 1'b0;
            end
        end
    end

    // Result sink: drop ready for the drawn stall after each item
    always @(posedge clk or negedge rst_n) begin : result_sink
        int stall;
        if (!rst_n) begin
            rsp_ch.ready <= 1'b0;
            rsp_wait     <= 0;
            rsp_burst    <= 1'b0;
        end
        else if (rsp_ch.valid && rsp_ch.ready) begin
            stall = rsp_burst ? 0 : $urandom_range(0, GAP_MAX);
            rsp_ch.ready <= (stall == 0);
            rsp_wait     <= stall;
            if ($urandom_range(0, 29) == 0)
                rsp_burst <= ~rsp_burst;
        end
        else if (rsp_wait > 0) begin
            rsp_ch.ready <= (rsp_wait == 1);
            rsp_wait     <= rsp_wait - 1;
        end
        else begin
            rsp_ch.ready <= 1'b1;
        end
    end

    // Monitor: check results first so that a result never meets the
    // expectation of the item taken at the same edge
    always @(posedge clk) begin : monitor
        rsp_t want;
        rsp_t got;
        if (!rst_n) begin
            bin_w = BIN_RESET;
            bin_h = BIN_RESET;
            restart_free_list();
        end
        else if (cycle_count >= CYCLE_LIMIT) begin
            $display("run stopped after %0d cycles, %0d results outstanding",
                     cycle_count, awaited_rsps.size());
            $display("[FAIL] regression broken");
            $finish;
        end
        else begin
            cycle_count++;
            if (rsp_ch.valid && rsp_ch.ready) begin
                got = rsp_ch.data;
                n_results++;
                if (awaited_rsps.size() == 0) begin
                    fail_count++;
                    if (report_count < REPORT_MAX)
                        $display("result %0d arrived with nothing outstanding: %p",
                                 n_results, got);
                    report_count++;
                end
                else begin
                    want = awaited_rsps.pop_front();
                    check_field("placed", COORD_W'(want.placed), COORD_W'(got.placed));
                    check_field("rect_left", want.rect_left, got.rect_left);
                    check_field("rect_top", want.rect_top, got.rect_top);
                    check_field("rect_right", want.rect_right, got.rect_right);
                    check_field("rect_bottom", want.rect_bottom, got.rect_bottom);
                    check_field("space_overflow", COORD_W'(want.space_overflow),
                                COORD_W'(got.space_overflow));
                end
            end
            if (req_ch.valid && req_ch.ready) begin
                want = place_rect(req_ch.data);
                awaited_rsps.insert(awaited_rsps.size(), want);
                n_requests++;
                if (want.placed)
                    n_placed++;
                if (want.space_overflow)
                    n_overflow++;
            end
            if (cfg_ch.valid && cfg_ch.ready) begin
                n_reg_writes++;
                if (cfg_ch.data.index == CFG_BIN_WIDTH) begin
                    bin_w = cfg_ch.data.value;
                    restart_free_list();
                end
                else if (cfg_ch.data.index == CFG_BIN_HEIGHT) begin
                    bin_h = cfg_ch.data.value;
                    restart_free_list();
                end
            end
        end
    end

    task automatic send_area(input int w, input int h);
        req_t a;
        a.area_width  = COORD_W'(w);
        a.area_height = COORD_W'(h);
        queued_areas.insert(queued_areas.size(), a);
    endtask

    // Hold the sender until every item has been taken and answered
    task automatic drain_all();
        do
            @(negedge clk);
        while (queued_areas.size() != 0 || req_ch.valid || awaited_rsps.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        cfg_t item;
        item.index = idx;
        item.value = COORD_W'(value);
        @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= item;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic run_phase(input int w, input int h, input int count, input area_mix_t mix);
        int n;
        drain_all();
        write_reg(CFG_BIN_WIDTH, w);
        write_reg(CFG_BIN_HEIGHT, h);
        for (n = 0; n < count; n++) begin
            do
                @(negedge clk);
            while (queued_areas.size() != 0);
            if ($urandom_range(0, 119) == 0)
                drain_all();
            queued_areas.insert(queued_areas.size(), draw_area(mix));
        end
    endtask

    initial begin : stimulus
        rst_n        <= 1'b0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.data  <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Default bin: zero-sized area with a tie, one-sided fits, misses
        send_area(0, 0);
        send_area(1, 1);
        send_area(1023, 1);
        send_area(4096, 4096);
        send_area(FIELD_MAX, FIELD_MAX);
        send_area(4097, 1);
        send_area(1, FIELD_MAX);
        send_area(1, 1024);
        drain_all();

        // Exact fit of the whole bin, then a request against an empty table
        write_reg(CFG_BIN_WIDTH, 4096);
        write_reg(CFG_BIN_HEIGHT, 4096);
        send_area(4096, 4096);
        send_area(0, 0);
        drain_all();

        // Oversized bin registers saturate
        write_reg(CFG_BIN_WIDTH, FIELD_MAX);
        write_reg(CFG_BIN_HEIGHT, FIELD_MAX);
        send_area(4096, 10);
        send_area(4096, 4086);
        send_area(100, 40);
        drain_all();

        // Zero-width bin only takes zero-width areas
        write_reg(CFG_BIN_WIDTH, 0);
        write_reg(CFG_BIN_HEIGHT, 5);
        send_area(0, 0);
        send_area(0, 5);
        send_area(1, 0);
        drain_all();

        // Writes to unused indexes leave the table alone
        write_reg(CFG_UNUSED_LOW, 77);
        write_reg(CFG_UNUSED_HIGH, FIELD_MAX);
        send_area(0, 0);
        drain_all();

        // Wide bin: splits that keep the right-hand piece, and misses
        write_reg(CFG_BIN_WIDTH, 100);
        write_reg(CFG_BIN_HEIGHT, 50);
        send_area(10, 10);
        send_area(40, 45);
        send_area(100, 50);
        send_area(90, 40);
        send_area(10, 40);

        run_phase(1024, 1024, 300, MIX_BROAD);
        run_phase(4096, 4096, 350, MIX_SMALL);
        run_phase(64, 48, 250, MIX_BROAD);
        run_phase(FIELD_MAX, 100, 200, MIX_BROAD);
        run_phase(1, 1, 100, MIX_BROAD);
        run_phase(0, 7, 100, MIX_BROAD);
        run_phase(13, 4096, 200, MIX_BROAD);
        run_phase(1024, 1024, 300, MIX_BROAD);

        drain_all();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("%0d areas requested: %0d placed, %0d missed, %0d split pieces dropped",
                 n_requests, n_placed, n_requests - n_placed, n_overflow);
        $display("%0d register writes across the bin sizes, %0d field mismatches, %0d cycles",
                 n_reg_writes, fail_count, cycle_count);
        if (fail_count == 0 && awaited_rsps.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
